FILE: rtl/l2c_pkg.sv
// Package for the GPS L2C CM/CL ranging code generator.
// Holds the code lengths, the shift register feedback mask, the per-satellite
// start-word tables and the configuration register indexes. No dependencies.
package l2c_pkg;

    localparam int SR_W        = 27;
    localparam int IDX_W       = 20;
    localparam int SAT_W       = 6;
    localparam int SLOT_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int SAT_COUNT   = 32;

    localparam logic [IDX_W-1:0] MODERATE_LENGTH = 20'd10230;
    localparam logic [IDX_W-1:0] LONG_LENGTH     = 20'd767250;

    localparam logic [SR_W-1:0] FEEDBACK_MASK = 27'o445112474;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SATELLITE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_CODE = 2'd1;

    localparam logic [SAT_W-1:0] SAT_MIN = 6'd1;
    localparam logic [SAT_W-1:0] SAT_MAX = 6'd32;

    localparam logic signed [1:0] CHIP_PLUS  = 2'sb01;
    localparam logic signed [1:0] CHIP_MINUS = 2'sb11;

    localparam logic [SR_W-1:0] CM_START [SAT_COUNT] = '{
        27'o742417664, 27'o756014035, 27'o002747144, 27'o066265724,
        27'o601403471, 27'o703232733, 27'o124510070, 27'o617316361,
        27'o047541621, 27'o733031046, 27'o713512145, 27'o024437606,
        27'o021264003, 27'o230655351, 27'o001314400, 27'o222021506,
        27'o540264026, 27'o205521705, 27'o064022144, 27'o120161274,
        27'o044023533, 27'o724744327, 27'o045743577, 27'o741201660,
        27'o700274134, 27'o010247261, 27'o713433445, 27'o737324162,
        27'o311627434, 27'o710452007, 27'o722462133, 27'o050172213
    };

    localparam logic [SR_W-1:0] CL_START [SAT_COUNT] = '{
        27'o624145772, 27'o506610362, 27'o220360016, 27'o710406104,
        27'o001143345, 27'o053023326, 27'o652521276, 27'o206124777,
        27'o015563374, 27'o561522076, 27'o023163525, 27'o117776450,
        27'o606516355, 27'o003037343, 27'o046515565, 27'o671511621,
        27'o605402220, 27'o002576207, 27'o525163451, 27'o266527765,
        27'o006760703, 27'o501474556, 27'o743747443, 27'o615534726,
        27'o763621420, 27'o720727474, 27'o700521043, 27'o222567263,
        27'o132765304, 27'o746332245, 27'o102300466, 27'o255231716
    };

    // Out-of-range satellite numbers are clamped into 1..32 before lookup.
    function automatic logic [SR_W-1:0] start_word(input logic [SAT_W-1:0] sat,
                                                   input logic             long_sel);
        logic [SAT_W-1:0]  sat_c;
        logic [SAT_W-1:0]  slot_w;
        logic [SLOT_W-1:0] slot;
        sat_c = sat;
        if (sat_c < SAT_MIN) begin
            sat_c = SAT_MIN;
        end
        if (sat_c > SAT_MAX) begin
            sat_c = SAT_MAX;
        end
        slot_w = sat_c - SAT_MIN;
        slot   = slot_w[SLOT_W-1:0];
        return long_sel ? CL_START[slot] : CM_START[slot];
    endfunction

endpackage

FILE: rtl/gps_l2c_code_generator_top.sv
// A chip appears on the result channel in the cycle after its transaction is accepted.
// One chip per cycle unless m_ready stalls; the shift register steps once per accepted chip.
// The output register is refilled in the same cycle it is drained, so no bubble is needed.
// Reset (aresetn low, synchronous): satellite 1, moderate code, register not loaded,
// output empty. The first chip after reset loads the satellite start word.
// Depends on l2c_pkg.
module gps_l2c_code_generator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [l2c_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [l2c_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_restart,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [1:0]                  m_chip,
    output logic                               m_last_chip
);

    logic [l2c_pkg::SAT_W-1:0]  sat_reg;
    logic                       long_reg;
    logic [l2c_pkg::SR_W-1:0]   sr_reg, sr_next;
    logic [l2c_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                       loaded_reg, loaded_next;
    logic                       m_valid_reg;
    logic signed [1:0]          chip_reg, chip_next;
    logic                       last_reg, last_next;

    logic                       accept;
    logic                       reload;
    logic [l2c_pkg::SR_W-1:0]   sr_cur;
    logic [l2c_pkg::IDX_W-1:0]  idx_cur;
    logic [l2c_pkg::IDX_W:0]    idx_inc;
    logic [l2c_pkg::IDX_W-1:0]  length;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign m_valid     = m_valid_reg;
    assign m_chip      = chip_reg;
    assign m_last_chip = last_reg;

    always_comb begin
        reload  = !loaded_reg || s_restart;
        sr_cur  = reload ? l2c_pkg::start_word(sat_reg, long_reg) : sr_reg;
        idx_cur = reload ? '0 : idx_reg;
        idx_inc = {1'b0, idx_cur} + {{l2c_pkg::IDX_W{1'b0}}, 1'b1};
        length  = long_reg ? l2c_pkg::LONG_LENGTH : l2c_pkg::MODERATE_LENGTH;

        chip_next   = sr_cur[0] ? l2c_pkg::CHIP_MINUS : l2c_pkg::CHIP_PLUS;
        last_next   = idx_inc >= {1'b0, length};
        sr_next     = (sr_cur >> 1) ^ (sr_cur[0] ? l2c_pkg::FEEDBACK_MASK : '0);
        idx_next    = idx_inc[l2c_pkg::IDX_W-1:0];
        loaded_next = !last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg     <= l2c_pkg::SAT_MIN;
            long_reg    <= 1'b0;
            sr_reg      <= '0;
            idx_reg     <= '0;
            loaded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    l2c_pkg::CFG_IDX_SATELLITE: sat_reg  <= cfg_data;
                    l2c_pkg::CFG_IDX_LONG_CODE: long_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                sr_reg     <= sr_next;
                idx_reg    <= idx_next;
                loaded_reg <= loaded_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            chip_reg <= chip_next;
            last_reg <= last_next;
        end
    end

`ifndef SYNTHESIS
    // An accepted transaction always leaves a result waiting in the next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction produced no result");

    // A held result is never a zero chip.
    a_chip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_chip == l2c_pkg::CHIP_PLUS || m_chip == l2c_pkg::CHIP_MINUS))
        else $error("chip value is not +1 or -1");

    // Flagging the last chip must force a reload on the following transaction.
    a_last_unloads: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last_next) |=> !loaded_reg)
        else $error("register still loaded after last chip");

    // The chip counter never runs past the long code length.
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= l2c_pkg::LONG_LENGTH)
        else $error("chip index beyond long code length");
`endif

endmodule

FILE: tb/l2c_chip_checker.sv
// Scoreboard for the L2C ranging code generator: predicts every chip from the
// accepted input transactions and the register writes, and compares each result.
// Depends on l2c_pkg for widths, code lengths, feedback mask and start-word tables.
module l2c_chip_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [l2c_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [l2c_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_restart,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [1:0]              m_chip,
    input  logic                           m_last_chip,
    output int                             failures,
    output int                             pending_chips
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [1:0] chip;
        logic              last_chip;
    } chip_result_t;

    chip_result_t               expected_chips[$];
    logic [l2c_pkg::SR_W-1:0]   code_reg;
    logic [l2c_pkg::IDX_W-1:0]  chip_count;
    logic                       code_loaded;
    logic [l2c_pkg::SAT_W-1:0]  prn_sel;
    logic                       long_sel;
    int                         chips_seen;

    // PRN 0 behaves as PRN 1, anything above the table behaves as the last entry.
    function automatic logic [l2c_pkg::SR_W-1:0] seed_word(
        input logic [l2c_pkg::SAT_W-1:0] prn,
        input logic                      use_long);
        int slot;
        if (prn == 0) begin
            slot = 0;
        end else if (int'(prn) > l2c_pkg::SAT_COUNT) begin
            slot = l2c_pkg::SAT_COUNT - 1;
        end else begin
            slot = int'(prn) - 1;
        end
        return use_long ? l2c_pkg::CL_START[slot] : l2c_pkg::CM_START[slot];
    endfunction

    task automatic predict_chip(input logic restart);
        chip_result_t result;
        int           period;
        logic         lsb;
        // The length test always uses the current code selection.
        period = long_sel ? int'(l2c_pkg::LONG_LENGTH) : int'(l2c_pkg::MODERATE_LENGTH);
        if (!code_loaded || restart) begin
            code_reg    = seed_word(prn_sel, long_sel);
            chip_count  = '0;
            code_loaded = 1'b1;
        end
        lsb              = code_reg[0];
        result.chip      = lsb ? l2c_pkg::CHIP_MINUS : l2c_pkg::CHIP_PLUS;
        result.last_chip = (int'(chip_count) + 1) >= period;
        code_reg         = (code_reg >> 1) ^ (lsb ? l2c_pkg::FEEDBACK_MASK : '0);
        chip_count       = chip_count + 1'b1;
        if (result.last_chip) begin
            code_loaded = 1'b0;
        end
        expected_chips.push_back(result);
    endtask

    task automatic check_chip();
        chip_result_t want;
        if (expected_chips.size() == 0) begin
            failures++;
            $error("chip %0d arrived with no transaction outstanding", chips_seen);
        end else begin
            want = expected_chips.pop_front();
            if (m_chip !== want.chip) begin
                failures++;
                $error("chip %0d: field chip expected %0d, actual %0d",
                       chips_seen, want.chip, m_chip);
            end
            if (m_last_chip !== want.last_chip) begin
                failures++;
                $error("chip %0d: field last_chip expected %0d, actual %0d",
                       chips_seen, want.last_chip, m_last_chip);
            end
        end
        chips_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_chips.delete();
            code_reg    = '0;
            chip_count  = '0;
            code_loaded = 1'b0;
            prn_sel     = l2c_pkg::SAT_MIN;
            long_sel    = 1'b0;
            chips_seen  = 0;
            failures    = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    l2c_pkg::CFG_IDX_SATELLITE: prn_sel = cfg_data;
                    l2c_pkg::CFG_IDX_LONG_CODE: long_sel = cfg_data[0];
                    default: ;
                endcase
            end
            // Compare before predicting so a stray output never consumes a fresh entry.
            if (m_valid && m_ready) begin
                check_chip();
            end
            if (s_valid && s_ready) begin
                predict_chip(s_restart);
            end
        end
        pending_chips = expected_chips.size();
    end

endmodule

FILE: tb/tb_gps_l2c_code_generator_top.sv
// Testbench top for gps_l2c_code_generator_top: clock, reset, register writes,
// chip requests and receiver back-pressure, plus the final verdict.
// Depends on l2c_pkg, the generator RTL and l2c_chip_checker.
module tb_gps_l2c_code_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 650;
    localparam int FINAL_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 100_000;

    // Indexes past the defined registers; writes to them must change nothing.
    localparam logic [l2c_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [l2c_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [l2c_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [l2c_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_restart;
    logic                           m_valid;
    logic                           m_ready;
    logic signed [1:0]              m_chip;
    logic                           m_last_chip;

    int failures;
    int pending_chips;
    int cycle_count;
    bit tx_jitter;
    bit rx_jitter;
    bit hold_req;

    gps_l2c_code_generator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_chip      (m_chip),
        .m_last_chip (m_last_chip)
    );

    l2c_chip_checker chip_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chip        (m_chip),
        .m_last_chip   (m_last_chip),
        .failures      (failures),
        .pending_chips (pending_chips)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gps_l2c_code_generator_top verification failed");
            $finish;
        end
    end

    // Receiver: random stalls while jitter is on, and one long hold on request.
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    @(negedge aclk);
                end
                hold_req = 1'b0;
            end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat (rx_jitter ? $urandom_range(1, 12) : 1) @(negedge aclk);
            end
        end
    end

    // All stimulus tasks are entered and left at a falling edge.
    task automatic send_chip(input logic restart);
        s_valid   <= 1'b1;
        s_restart <= restart;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        s_valid   <= 1'b0;
        s_restart <= 1'($urandom_range(0, 1));
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic offer_chip(input logic restart);
        if (tx_jitter && $urandom_range(0, 4) == 0) begin
            idle_sender($urandom_range(1, 8));
        end
        send_chip(restart);
    endtask

    // restart_rate is the chance of a restart in 256ths.
    task automatic run_chips(input int count, input int restart_rate);
        for (int i = 0; i < count; i++) begin
            offer_chip(int'($urandom_range(0, 255)) < restart_rate);
        end
    endtask

    // Registers change only with the generator drained.
    task automatic write_reg(input logic [l2c_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [l2c_pkg::CFG_DATA_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_chips != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int items;
        int span;
        int rate;
        int phase;

        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_restart   = 1'b0;
        tx_jitter   = 1'b0;
        rx_jitter   = 1'b0;
        hold_req    = 1'b0;
        cycle_count = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The first chip after reset loads satellite 1 without a restart.
        send_chip(1'b0);
        send_chip(1'b0);
        send_chip(1'b0);
        send_chip(1'b1);
        send_chip(1'b0);
        // Satellite numbers outside 1..32 are clamped.
        write_reg(l2c_pkg::CFG_IDX_SATELLITE, 6'd0);
        send_chip(1'b1);
        send_chip(1'b0);
        write_reg(l2c_pkg::CFG_IDX_SATELLITE, l2c_pkg::SAT_MAX);
        send_chip(1'b1);
        write_reg(l2c_pkg::CFG_IDX_SATELLITE, 6'd63);
        send_chip(1'b1);
        write_reg(l2c_pkg::CFG_IDX_SATELLITE, 6'd33);
        send_chip(1'b1);
        write_reg(l2c_pkg::CFG_IDX_LONG_CODE, 6'h3F);
        send_chip(1'b1);
        send_chip(1'b0);
        write_reg(CFG_IDX_SPARE_LO, 6'h3F);
        write_reg(CFG_IDX_SPARE_HI, 6'h00);
        send_chip(1'b0);
        // A new satellite waits for the next reload.
        write_reg(l2c_pkg::CFG_IDX_SATELLITE, 6'd17);
        send_chip(1'b0);
        send_chip(1'b0);
        send_chip(1'b1);
        send_chip(1'b0);
        write_reg(l2c_pkg::CFG_IDX_LONG_CODE, 6'h3E);
        send_chip(1'b0);
        send_chip(1'b1);

        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS) begin
            span = $urandom_range(20, 120);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(l2c_pkg::CFG_IDX_SATELLITE, 6'($urandom_range(0, 63)));
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(l2c_pkg::CFG_IDX_LONG_CODE, 6'($urandom_range(0, 63)));
            end
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
            rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (phase == 1) begin
                // Long receiver hold while the sender keeps offering chips.
                hold_req = 1'b1;
                span     = 120;
            end
            send_chip($urandom_range(0, 3) != 0);
            run_chips(span - 1, rate);
            items += span;
            phase++;
        end

        // Final stretch without idling on the long code.
        write_reg(l2c_pkg::CFG_IDX_LONG_CODE, 6'd1);
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        send_chip(1'b1);
        run_chips(FINAL_ITEMS - 1, 16);

        s_valid <= 1'b0;
        while (pending_chips != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (failures == 0) begin
            $display("gps_l2c_code_generator_top verification clean");
        end else begin
            $display("gps_l2c_code_generator_top verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/l2c_pkg.sv
rtl/gps_l2c_code_generator_top.sv
tb/l2c_chip_checker.sv
tb/tb_gps_l2c_code_generator_top.sv
